FILE: rtl/core/id3tfp_pkg.sv
package id3tfp_pkg;

    typedef logic [4:0] t_kind;
    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_SELECT_ALL = 1'b0;
    localparam t_cfg_index CFG_WANTED_ID  = 1'b1;

    localparam logic [3:0] HDR_LEN     = 4'd10;
    localparam logic [3:0] VERSION_POS = 4'd3;
    localparam logic [3:0] ID_END      = 4'd4;
    localparam logic [3:0] SIZE_END    = 4'd8;

    localparam logic [7:0] PRINT_MIN = 8'd32;
    localparam logic [7:0] PRINT_MAX = 8'd126;

    localparam t_kind KIND_TEXT      = 5'd0;
    localparam t_kind KIND_COMMENT   = 5'd1;
    localparam t_kind KIND_URL       = 5'd2;
    localparam t_kind KIND_CD_ID     = 5'd3;
    localparam t_kind KIND_EVENT     = 5'd4;
    localparam t_kind KIND_SYNC_TEXT = 5'd5;
    localparam t_kind KIND_UNSYNC    = 5'd6;
    localparam t_kind KIND_REL_VOL   = 5'd7;
    localparam t_kind KIND_EQUAL     = 5'd8;
    localparam t_kind KIND_PICTURE   = 5'd9;
    localparam t_kind KIND_PLAY_CNT  = 5'd10;
    localparam t_kind KIND_POPULAR   = 5'd11;
    localparam t_kind KIND_BUF_SIZE  = 5'd12;
    localparam t_kind KIND_LINK      = 5'd13;
    localparam t_kind KIND_POSITION  = 5'd14;
    localparam t_kind KIND_TERMS     = 5'd15;
    localparam t_kind KIND_OWNER     = 5'd16;
    localparam t_kind KIND_ENCRYPT   = 5'd17;
    localparam t_kind KIND_GROUP     = 5'd18;
    localparam t_kind KIND_PRIVATE   = 5'd19;
    localparam t_kind KIND_SIGNATURE = 5'd20;
    localparam t_kind KIND_SEEK      = 5'd21;
    localparam t_kind KIND_NONE      = 5'd22;

    // first matching test wins
    function automatic t_kind classify(input logic [31:0] id);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        t_kind      k;
        a = id[31:24];
        b = id[23:16];
        c = id[15:8];
        if (a == "T")                    k = KIND_TEXT;
        else if (a == "C")               k = KIND_COMMENT;
        else if (a == "W")               k = KIND_URL;
        else if (a == "M" && b == "C")   k = KIND_CD_ID;
        else if (a == "E" && b == "T")   k = KIND_EVENT;
        else if (a == "S" && b == "Y")   k = KIND_SYNC_TEXT;
        else if (a == "U" && c == "L")   k = KIND_UNSYNC;
        else if (a == "R" && c == "A")   k = KIND_REL_VOL;
        else if (a == "E" && b == "Q")   k = KIND_EQUAL;
        else if (a == "A" && b == "P")   k = KIND_PICTURE;
        else if (a == "P" && b == "C")   k = KIND_PLAY_CNT;
        else if (a == "P" && c == "P")   k = KIND_POPULAR;
        else if (a == "R" && b == "B")   k = KIND_BUF_SIZE;
        else if (a == "L")               k = KIND_LINK;
        else if (a == "P" && c == "S")   k = KIND_POSITION;
        else if (a == "U" && c == "E")   k = KIND_TERMS;
        else if (a == "O")               k = KIND_OWNER;
        else if (a == "E" && b == "N")   k = KIND_ENCRYPT;
        else if (a == "G" && b == "R")   k = KIND_GROUP;
        else if (a == "P" && b == "R")   k = KIND_PRIVATE;
        else if (a == "S" && b == "I")   k = KIND_SIGNATURE;
        else if (a == "S" && b == "E")   k = KIND_SEEK;
        else                             k = KIND_NONE;
        return k;
    endfunction

    function automatic logic has_zero_byte(input logic [31:0] id);
        return (id[31:24] == 8'd0) || (id[23:16] == 8'd0) ||
               (id[15:8] == 8'd0) || (id[7:0] == 8'd0);
    endfunction

endpackage

FILE: rtl/core/id3_tag_frame_parser_core.sv
// The result of an accepted byte is registered in the output register in the next cycle.
// Throughput: one byte per cycle; the next request is taken while a result waits,
// as long as the output register is empty or is being emptied in the same cycle.
// All parsing for a byte is done by the classifier, compares and the 32-bit
// payload counter between the input handshake and the output register.
// Reset (synchronous, active low) selects all frames and restarts at the tag header.
module id3_tag_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_tag,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_is_version,
    output logic [4:0]  o_frame_kind,
    output logic [31:0] o_frame_id,
    output logic        o_last_of_frame
);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_HDR,
        PH_PAY,
        PH_STOP
    } t_phase;

    logic                r_select_all;
    logic [31:0]         r_wanted_id;

    t_phase              r_phase, n_phase;
    logic [3:0]          r_hdr_cnt, n_hdr_cnt;
    logic [31:0]         r_id, n_id;
    logic [31:0]         r_size, n_size;
    logic [31:0]         r_left, n_left;
    id3tfp_pkg::t_kind   r_kind, n_kind;
    logic                r_emit, n_emit;

    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_char, n_out_char;
    logic                r_char_valid, n_char_valid;
    logic                r_is_version, n_is_version;
    id3tfp_pkg::t_kind   r_frame_kind, n_frame_kind;
    logic [31:0]         r_frame_id, n_frame_id;
    logic                r_last, n_last;

    logic                in_acc;
    t_phase              cur_phase;
    logic [3:0]          cur_cnt;
    logic [31:0]         cur_id;
    logic [31:0]         cur_size;
    logic [3:0]          cnt_inc;
    logic                printable;
    logic                last_byte;
    id3tfp_pkg::t_kind   new_kind;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        // start of tag restarts the parse before this byte is taken
        cur_phase = i_start_of_tag ? PH_TAG : r_phase;
        cur_cnt   = i_start_of_tag ? 4'd0 : r_hdr_cnt;
        cur_id    = i_start_of_tag ? 32'd0 : r_id;
        cur_size  = i_start_of_tag ? 32'd0 : r_size;
        cnt_inc   = cur_cnt + 4'd1;
        printable = (i_data_byte >= id3tfp_pkg::PRINT_MIN) &&
                    (i_data_byte <= id3tfp_pkg::PRINT_MAX);
        last_byte = (r_left == 32'd1);
        new_kind  = id3tfp_pkg::classify(cur_id);

        n_phase   = cur_phase;
        n_hdr_cnt = cur_cnt;
        n_id      = cur_id;
        n_size    = cur_size;
        n_left    = i_start_of_tag ? 32'd0 : r_left;
        n_kind    = i_start_of_tag ? id3tfp_pkg::KIND_TEXT : r_kind;
        n_emit    = i_start_of_tag ? 1'b0 : r_emit;

        n_out_valid  = 1'b0;
        n_out_char   = 8'd0;
        n_char_valid = 1'b0;
        n_is_version = 1'b0;
        n_frame_kind = id3tfp_pkg::KIND_TEXT;
        n_frame_id   = 32'd0;
        n_last       = 1'b0;

        case (cur_phase)
            PH_TAG: begin
                if (cur_cnt == id3tfp_pkg::VERSION_POS) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = i_data_byte;
                    n_char_valid = 1'b1;
                    n_is_version = 1'b1;
                end
                n_hdr_cnt = cnt_inc;
                if (cnt_inc >= id3tfp_pkg::HDR_LEN) begin
                    n_hdr_cnt = 4'd0;
                    n_phase   = PH_HDR;
                end
            end
            PH_HDR: begin
                if (cur_cnt < id3tfp_pkg::ID_END) begin
                    n_id = {cur_id[23:0], i_data_byte};
                end else if (cur_cnt < id3tfp_pkg::SIZE_END) begin
                    n_size = {cur_size[23:0], i_data_byte};
                end
                n_hdr_cnt = cnt_inc;
                // last header byte is a flag byte, so the ID and size are complete
                if (cnt_inc >= id3tfp_pkg::HDR_LEN) begin
                    n_hdr_cnt = 4'd0;
                    if (id3tfp_pkg::has_zero_byte(cur_id)) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_kind  = new_kind;
                        n_emit  = (new_kind != id3tfp_pkg::KIND_NONE) &&
                                  (r_select_all || (cur_id == r_wanted_id));
                        n_left  = cur_size;
                        n_phase = (cur_size != 32'd0) ? PH_PAY : PH_HDR;
                    end
                end
            end
            PH_PAY: begin
                n_left = r_left - 32'd1;
                if (r_emit && (printable || last_byte)) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = printable ? i_data_byte : 8'd0;
                    n_char_valid = printable;
                    n_frame_kind = r_kind;
                    n_frame_id   = r_id;
                    n_last       = last_byte;
                end
                if (last_byte) begin
                    n_phase   = PH_HDR;
                    n_hdr_cnt = 4'd0;
                end
            end
            default: begin
                // stopped: drop bytes until the next start of tag
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_all <= 1'b1;
            r_wanted_id  <= 32'd0;
            r_phase      <= PH_TAG;
            r_hdr_cnt    <= 4'd0;
            r_id         <= 32'd0;
            r_size       <= 32'd0;
            r_left       <= 32'd0;
            r_kind       <= id3tfp_pkg::KIND_TEXT;
            r_emit       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    id3tfp_pkg::CFG_SELECT_ALL: r_select_all <= i_cfg_data[0];
                    id3tfp_pkg::CFG_WANTED_ID:  r_wanted_id  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_id        <= n_id;
                r_size      <= n_size;
                r_left      <= n_left;
                r_kind      <= n_kind;
                r_emit      <= n_emit;
                r_out_valid <= n_out_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload holds until the next accepted request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_char   <= n_out_char;
            r_char_valid <= n_char_valid;
            r_is_version <= n_is_version;
            r_frame_kind <= n_frame_kind;
            r_frame_id   <= n_frame_id;
            r_last       <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_char_valid    = r_char_valid;
    assign o_is_version    = r_is_version;
    assign o_frame_kind    = r_frame_kind;
    assign o_frame_id      = r_frame_id;
    assign o_last_of_frame = r_last;

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_start_of_tag && r_phase == PH_STOP) |=> !o_out_valid)
        else $error("result produced while parsing is stopped");

    a_version_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_version) |->
            (o_char_valid && !o_last_of_frame && o_frame_kind == id3tfp_pkg::KIND_TEXT))
        else $error("malformed version result");

    a_known_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_version) |-> (o_frame_kind != id3tfp_pkg::KIND_NONE))
        else $error("payload result from unrecognised frame");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_start_of_tag && r_phase == PH_PAY && r_left == 32'd1) |=>
            (r_phase == PH_HDR && r_hdr_cnt == 4'd0))
        else $error("frame end did not return to header parsing");

endmodule
